FILE: sv/irbm_pkg.sv
// ----------------------------------------------------------------------------
// irbm_pkg
// Shared types and codes for the I2C register burst master.
// ----------------------------------------------------------------------------
package irbm_pkg;

  localparam int MAX_BURST_DEF = 16;

  // input operations
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DEV_ADDR = 2'd0;
  localparam logic [1:0] CFG_REG_ADDR = 2'd1;
  localparam logic [1:0] CFG_XFER_LEN = 2'd2;
  localparam logic [1:0] CFG_DIR      = 2'd3;

  localparam logic [6:0] DEV_ADDR_RST = 7'd104;
  localparam logic [7:0] REG_ADDR_RST = 8'd0;
  localparam logic [4:0] XFER_LEN_RST = 5'd1;
  localparam logic       DIR_RST      = 1'b0;

  localparam logic [7:0] BIT_MSB = 8'h80;

  // sequencer phases
  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] PH_ST_SDA1 = 5'd1;
  localparam logic [4:0] PH_ST_SCL1 = 5'd2;
  localparam logic [4:0] PH_ST_SDA0 = 5'd3;
  localparam logic [4:0] PH_ST_SCL0 = 5'd4;
  localparam logic [4:0] PH_TX_SDA  = 5'd5;
  localparam logic [4:0] PH_TX_SCLH = 5'd6;
  localparam logic [4:0] PH_TX_SCLL = 5'd7;
  localparam logic [4:0] PH_AK_SDA  = 5'd8;
  localparam logic [4:0] PH_AK_SCLH = 5'd9;
  localparam logic [4:0] PH_AK_SCLL = 5'd10;
  localparam logic [4:0] PH_RX_REL  = 5'd11;
  localparam logic [4:0] PH_RX_SCLH = 5'd12;
  localparam logic [4:0] PH_RX_SCLL = 5'd13;
  localparam logic [4:0] PH_MA_SDA  = 5'd14;
  localparam logic [4:0] PH_MA_SCLH = 5'd15;
  localparam logic [4:0] PH_MA_SCLL = 5'd16;
  localparam logic [4:0] PH_SP_SDA0 = 5'd17;
  localparam logic [4:0] PH_SP_SCL1 = 5'd18;
  localparam logic [4:0] PH_SP_SDA1 = 5'd19;

  // which byte of the frame is on the wire
  localparam logic [1:0] LEG_ADDR_W = 2'd0;
  localparam logic [1:0] LEG_REG    = 2'd1;
  localparam logic [1:0] LEG_DATA   = 2'd2;
  localparam logic [1:0] LEG_ADDR_R = 2'd3;

  typedef struct packed {
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [4:0] xfer_len;
    logic       dir;
  } irbm_cfg_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       ack_seen;
    logic       busy;
    logic       done;
  } irbm_res_t;

endpackage

FILE: sv/irbm_wbuf.sv
// ----------------------------------------------------------------------------
// irbm_wbuf
// Write data buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module irbm_wbuf #(
  parameter int MAX_BURST = irbm_pkg::MAX_BURST_DEF,
  localparam int AW = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [MAX_BURST];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/irbm_seq.sv
// ----------------------------------------------------------------------------
// irbm_seq
// Line sequencer: one line action per tick beat, byte shifting, ack slots.
// ----------------------------------------------------------------------------
module irbm_seq #(
  parameter int MAX_BURST = irbm_pkg::MAX_BURST_DEF,
  localparam int AW = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1,
  localparam int PW = $clog2(MAX_BURST + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [1:0]          op,
  input  logic [7:0]          wbyte,
  input  logic                sda_in,
  input  irbm_pkg::irbm_cfg_t cfg,
  input  logic [7:0]          rd_data,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [7:0]          wr_data,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  output irbm_pkg::irbm_res_t res
);

  localparam logic [PW-1:0] MAXP = PW'(MAX_BURST);
  localparam logic [8:0]    MAX9 = 9'(MAX_BURST);

  logic [4:0]    phase_r, phase_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [PW-1:0] left_r, left_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [1:0]    leg_r, leg_nxt;
  logic          scl_r, scl_nxt;
  logic          sda_r, sda_nxt;

  logic          busy;
  logic [8:0]    len9;
  logic [7:0]    data_byte;
  logic [7:0]    rx_shift;
  logic [PW-1:0] left_dec;

  assign busy      = (phase_r != irbm_pkg::PH_IDLE);
  assign data_byte = (ptr_r < MAXP) ? rd_data : 8'd0;
  assign rx_shift  = shift_r | (sda_in ? (irbm_pkg::BIT_MSB >> bit_r) : 8'd0);
  assign left_dec  = (left_r != '0) ? (left_r - PW'(1)) : left_r;

  always_comb begin
    len9 = {4'd0, cfg.xfer_len};
    if (len9 == 9'd0) begin
      len9 = 9'd1;
    end
    if (len9 > MAX9) begin
      len9 = MAX9;
    end
  end

  assign wr_en   = step && (op == irbm_pkg::OP_LOAD) && !busy && (ptr_r < MAXP);
  assign wr_addr = ptr_r[AW-1:0];
  assign wr_data = wbyte;
  // keep the buffer output tracking the entry the pointer will name next
  assign rd_en   = (ptr_nxt < MAXP);
  assign rd_addr = ptr_nxt[AW-1:0];

  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    left_nxt  = left_r;
    shift_nxt = shift_r;
    ptr_nxt   = ptr_r;
    leg_nxt   = leg_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    res       = '0;

    if (step) begin
      if (op == irbm_pkg::OP_BEGIN) begin
        if (!busy) begin
          left_nxt  = len9[PW-1:0];
          ptr_nxt   = '0;
          leg_nxt   = irbm_pkg::LEG_ADDR_W;
          bit_nxt   = 3'd0;
          shift_nxt = {cfg.dev_addr, 1'b0};
          phase_nxt = irbm_pkg::PH_ST_SDA1;
        end
      end else if (op == irbm_pkg::OP_LOAD) begin
        if (wr_en) begin
          ptr_nxt = ptr_r + PW'(1);
        end
      end else if (op == irbm_pkg::OP_TICK && busy) begin
        case (phase_r)
          irbm_pkg::PH_ST_SDA1: begin
            sda_nxt = 1'b1; phase_nxt = irbm_pkg::PH_ST_SCL1;
          end
          irbm_pkg::PH_ST_SCL1: begin
            scl_nxt = 1'b1; phase_nxt = irbm_pkg::PH_ST_SDA0;
          end
          irbm_pkg::PH_ST_SDA0: begin
            sda_nxt = 1'b0; phase_nxt = irbm_pkg::PH_ST_SCL0;
          end
          irbm_pkg::PH_ST_SCL0: begin
            scl_nxt = 1'b0; bit_nxt = 3'd0; phase_nxt = irbm_pkg::PH_TX_SDA;
          end
          irbm_pkg::PH_TX_SDA: begin
            sda_nxt   = ((shift_r & (irbm_pkg::BIT_MSB >> bit_r)) != 8'd0);
            phase_nxt = irbm_pkg::PH_TX_SCLH;
          end
          irbm_pkg::PH_TX_SCLH: begin
            scl_nxt = 1'b1; phase_nxt = irbm_pkg::PH_TX_SCLL;
          end
          irbm_pkg::PH_TX_SCLL: begin
            scl_nxt = 1'b0;
            if (bit_r == 3'd7) begin
              bit_nxt = 3'd0; phase_nxt = irbm_pkg::PH_AK_SDA;
            end else begin
              bit_nxt = bit_r + 3'd1; phase_nxt = irbm_pkg::PH_TX_SDA;
            end
          end
          irbm_pkg::PH_AK_SDA: begin
            sda_nxt = 1'b1; phase_nxt = irbm_pkg::PH_AK_SCLH;
          end
          irbm_pkg::PH_AK_SCLH: begin
            scl_nxt = 1'b1; res.ack_seen = sda_in; phase_nxt = irbm_pkg::PH_AK_SCLL;
          end
          irbm_pkg::PH_AK_SCLL: begin
            scl_nxt = 1'b0;
            bit_nxt = 3'd0;
            case (leg_r)
              irbm_pkg::LEG_ADDR_W: begin
                shift_nxt = cfg.reg_addr;
                leg_nxt   = irbm_pkg::LEG_REG;
                phase_nxt = irbm_pkg::PH_TX_SDA;
              end
              irbm_pkg::LEG_REG: begin
                if (cfg.dir) begin
                  // repeated start, then address with the read bit
                  shift_nxt = {cfg.dev_addr, 1'b1};
                  leg_nxt   = irbm_pkg::LEG_ADDR_R;
                  phase_nxt = irbm_pkg::PH_ST_SDA1;
                end else begin
                  shift_nxt = data_byte;
                  if (ptr_r < MAXP) begin
                    ptr_nxt = ptr_r + PW'(1);
                  end
                  leg_nxt   = irbm_pkg::LEG_DATA;
                  phase_nxt = irbm_pkg::PH_TX_SDA;
                end
              end
              irbm_pkg::LEG_DATA: begin
                left_nxt = left_dec;
                if (left_dec != '0) begin
                  shift_nxt = data_byte;
                  if (ptr_r < MAXP) begin
                    ptr_nxt = ptr_r + PW'(1);
                  end
                  phase_nxt = irbm_pkg::PH_TX_SDA;
                end else begin
                  phase_nxt = irbm_pkg::PH_SP_SDA0;
                end
              end
              default: begin
                phase_nxt = irbm_pkg::PH_RX_REL;
              end
            endcase
          end
          irbm_pkg::PH_RX_REL: begin
            sda_nxt   = 1'b1;
            shift_nxt = 8'd0;
            bit_nxt   = 3'd0;
            phase_nxt = irbm_pkg::PH_RX_SCLH;
          end
          irbm_pkg::PH_RX_SCLH: begin
            scl_nxt   = 1'b1;
            shift_nxt = rx_shift;
            if (bit_r == 3'd7) begin
              res.read_valid = 1'b1;
              res.read_byte  = rx_shift;
              res.read_last  = (left_r == PW'(1));
            end
            phase_nxt = irbm_pkg::PH_RX_SCLL;
          end
          irbm_pkg::PH_RX_SCLL: begin
            scl_nxt = 1'b0;
            if (bit_r == 3'd7) begin
              bit_nxt = 3'd0; phase_nxt = irbm_pkg::PH_MA_SDA;
            end else begin
              bit_nxt = bit_r + 3'd1; phase_nxt = irbm_pkg::PH_RX_SCLH;
            end
          end
          irbm_pkg::PH_MA_SDA: begin
            // nack on the last byte
            sda_nxt   = (left_r <= PW'(1));
            phase_nxt = irbm_pkg::PH_MA_SCLH;
          end
          irbm_pkg::PH_MA_SCLH: begin
            scl_nxt = 1'b1; phase_nxt = irbm_pkg::PH_MA_SCLL;
          end
          irbm_pkg::PH_MA_SCLL: begin
            scl_nxt   = 1'b0;
            left_nxt  = left_dec;
            phase_nxt = (left_dec != '0) ? irbm_pkg::PH_RX_REL : irbm_pkg::PH_SP_SDA0;
          end
          irbm_pkg::PH_SP_SDA0: begin
            sda_nxt = 1'b0; phase_nxt = irbm_pkg::PH_SP_SCL1;
          end
          irbm_pkg::PH_SP_SCL1: begin
            scl_nxt = 1'b1; phase_nxt = irbm_pkg::PH_SP_SDA1;
          end
          irbm_pkg::PH_SP_SDA1: begin
            sda_nxt   = 1'b1;
            res.done  = 1'b1;
            ptr_nxt   = '0;
            phase_nxt = irbm_pkg::PH_IDLE;
          end
          default: begin
            phase_nxt = irbm_pkg::PH_IDLE;
          end
        endcase
      end
    end

    res.scl_level = scl_nxt;
    res.sda_drive = sda_nxt;
    res.busy      = (phase_nxt != irbm_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= irbm_pkg::PH_IDLE;
      bit_r   <= 3'd0;
      left_r  <= '0;
      shift_r <= 8'd0;
      ptr_r   <= '0;
      leg_r   <= irbm_pkg::LEG_ADDR_W;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      left_r  <= left_nxt;
      shift_r <= shift_nxt;
      ptr_r   <= ptr_nxt;
      leg_r   <= leg_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
    end
  end

endmodule

FILE: sv/i2c_register_burst_master_top.sv
// ----------------------------------------------------------------------------
// i2c_register_burst_master_top
// I2C master for register write and read bursts on open-drain SCL/SDA. Each
// input beat is one operation: a tick performs exactly one line action while
// busy; while idle, a begin starts a transaction with the current
// configuration and a load appends one byte to the write buffer if not full.
// Every input beat yields exactly one result beat carrying the line drives
// after that step, a received byte when its eighth bit is sampled, the
// sampled slave acknowledge, and the busy/done flags. Each beat is registered
// into the result register, so one beat per cycle is sustained while results
// are taken: a new beat is taken when no result is held or the held one is
// taken in the same cycle. Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
module i2c_register_burst_master_top #(
  parameter int MAX_BURST = irbm_pkg::MAX_BURST_DEF
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_write_byte,
  input  logic       in_sda_in,

  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_scl_level,
  output logic       out_sda_drive,
  output logic [7:0] out_read_byte,
  output logic       out_read_valid,
  output logic       out_read_last,
  output logic       out_ack_seen,
  output logic       out_busy_res,
  output logic       out_done_res,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int AW = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;

  irbm_pkg::irbm_cfg_t cfg_r;
  irbm_pkg::irbm_res_t res;
  irbm_pkg::irbm_res_t res_r;
  logic                out_valid_r;
  logic                step;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [7:0]          wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [7:0]          rd_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign step      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dev_addr <= irbm_pkg::DEV_ADDR_RST;
      cfg_r.reg_addr <= irbm_pkg::REG_ADDR_RST;
      cfg_r.xfer_len <= irbm_pkg::XFER_LEN_RST;
      cfg_r.dir      <= irbm_pkg::DIR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        irbm_pkg::CFG_DEV_ADDR: cfg_r.dev_addr <= cfg_data[6:0];
        irbm_pkg::CFG_REG_ADDR: cfg_r.reg_addr <= cfg_data;
        irbm_pkg::CFG_XFER_LEN: cfg_r.xfer_len <= cfg_data[4:0];
        irbm_pkg::CFG_DIR:      cfg_r.dir      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  irbm_seq #(
    .MAX_BURST(MAX_BURST)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .op      (in_op),
    .wbyte   (in_write_byte),
    .sda_in  (in_sda_in),
    .cfg     (cfg_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .res     (res)
  );

  irbm_wbuf #(
    .MAX_BURST(MAX_BURST)
  ) u_wbuf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result register: a new beat loads when none is held or the held one is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_scl_level  = res_r.scl_level;
  assign out_sda_drive  = res_r.sda_drive;
  assign out_read_byte  = res_r.read_byte;
  assign out_read_valid = res_r.read_valid;
  assign out_read_last  = res_r.read_last;
  assign out_ack_seen   = res_r.ack_seen;
  assign out_busy_res   = res_r.busy;
  assign out_done_res   = res_r.done;

endmodule
